// ===== sv/scaled_vector3_magnitude_core_assert.svh =====
// Assertion macros for the scaled vector magnitude core.
// Used by the top level; no dependencies.
`ifndef SCALED_VECTOR3_MAGNITUDE_CORE_ASSERT_SVH
`define SCALED_VECTOR3_MAGNITUDE_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define SVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/svm_pkg.sv =====
// Package for the scaled vector magnitude core: default widths and the output width.
// No dependencies.
`timescale 1ns / 1ps
package svm_pkg;
    localparam int unsigned DEF_DATA_WIDTH = 32;
    localparam int unsigned DEF_FRAC_BITS  = 16;
    localparam int unsigned OUT_WIDTH      = 32;
endpackage

// ===== sv/svm_if.sv =====
// Valid/ready channel interface carrying a payload of parameterized width.
// No dependencies.
`timescale 1ns / 1ps
interface svm_if #(parameter int unsigned W = 32) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/svm_div_cell.sv =====
// One restoring-division cell: produces one quotient bit for each of three lanes.
// Depends on svm_pkg.
`timescale 1ns / 1ps
module svm_div_cell import svm_pkg::*; #(
    parameter int unsigned AW = 33,
    parameter int unsigned QW = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_w,
    input  logic [3*(AW+1)-1:0] i_rem,
    input  logic [3*QW-1:0]     i_quo,
    input  logic [3*AW-1:0]     i_num,
    input  logic [AW-1:0] i_aux,
    output logic [AW-1:0] o_w,
    output logic [3*(AW+1)-1:0] o_rem,
    output logic [3*QW-1:0]     o_quo,
    output logic [3*AW-1:0]     o_num,
    output logic [AW-1:0] o_aux
);
    logic [3*(AW+1)-1:0] n_rem;
    logic [3*QW-1:0]     n_quo;
    logic [3*AW-1:0]     n_num;

    always_comb begin
        logic [AW+1:0] t;
        logic [AW+1:0] d;
        for (int k = 0; k < 3; k++) begin
            t = {i_rem[k*(AW+1) +: AW+1], i_num[k*AW+AW-1]};
            d = t - {2'b00, i_w};
            if (!d[AW+1]) begin
                n_rem[k*(AW+1) +: AW+1] = d[AW:0];
                n_quo[k*QW +: QW] = {i_quo[k*QW +: QW-1], 1'b1};
            end else begin
                n_rem[k*(AW+1) +: AW+1] = t[AW:0];
                n_quo[k*QW +: QW] = {i_quo[k*QW +: QW-1], 1'b0};
            end
            n_num[k*AW +: AW] = {i_num[k*AW +: AW-1], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_w   <= i_w;
            o_rem <= n_rem;
            o_quo <= n_quo;
            o_num <= n_num;
            o_aux <= i_aux;
        end
    end
endmodule

// ===== sv/svm_sqrt_cell.sv =====
// One square-root cell: resolves one root bit of the digit-by-digit method.
// Depends on svm_pkg.
`timescale 1ns / 1ps
module svm_sqrt_cell import svm_pkg::*; #(
    parameter int unsigned NW = 36,
    parameter int unsigned RW = 18,
    parameter int unsigned AW = 33
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [RW:0]   i_rem,
    input  logic [RW-1:0] i_root,
    input  logic [AW-1:0] i_w,
    output logic [NW-1:0] o_num,
    output logic [RW:0]   o_rem,
    output logic [RW-1:0] o_root,
    output logic [AW-1:0] o_w
);
    logic [RW+2:0] t;
    logic [RW+2:0] d;
    always_comb begin
        t = {i_rem, i_num[NW-1:NW-2]};
        d = t - {1'b0, i_root, 2'b01};
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num  <= {i_num[NW-3:0], 2'b00};
            o_w    <= i_w;
            if (!d[RW+2]) begin
                o_rem  <= d[RW:0];
                o_root <= {i_root[RW-2:0], 1'b1};
            end else begin
                o_rem  <= t[RW:0];
                o_root <= {i_root[RW-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== sv/scaled_vector3_magnitude_core.sv =====
// Top level of the scaled vector magnitude core: absolute values, division and
// square-root cell chains, final scaling. Depends on svm_pkg, svm_if, the cells.
`timescale 1ns / 1ps
// This core returns a floored estimate of the Euclidean length of a 3-D signed
// vector. It scales every component by the largest absolute value w, so
// each ratio is a fixed-point fraction with FRAC_BITS fraction bits, takes the
// integer square root of the sum of the squared ratios and multiplies back by
// w. The core is a pipeline: one stage for absolute values and maximum, a
// chain of FRAC_BITS+DATA_WIDTH+1 division cells (one quotient bit per cell,
// all three lanes side by side), one stage each for squaring and summing,
// a chain of FRAC_BITS+2 square-root cells (one root bit each), a multiply
// stage and the output register. A new item is taken in every cycle unless
// the sink stalls: the whole pipeline advances only when the output register
// is empty or being read, so a stalled sink halts it and nothing is lost; a
// vector of all zeros yields zero.
module scaled_vector3_magnitude_core import svm_pkg::*; #(
    parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    svm_if.sink   i_vec,
    svm_if.source o_mag
);
    localparam int unsigned AW  = DATA_WIDTH + 1;
    localparam int unsigned QW  = FRAC_BITS + 1;
    localparam int unsigned NDIV = AW + FRAC_BITS;
    localparam int unsigned SW  = 2 * QW + 2;
    localparam int unsigned RW  = SW / 2;
    localparam int unsigned NSQ = RW;
    localparam int unsigned PW  = AW + RW;
    localparam int unsigned NST = NDIV + NSQ + 4;

    logic en;
    logic [NST-1:0] r_vld;
    logic r_out_vld;
    logic [OUT_WIDTH-1:0] r_out;

    assign en = !r_out_vld || o_mag.ready;
    assign i_vec.ready = en;
    assign o_mag.valid = r_out_vld;
    assign o_mag.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[NST-2:0], i_vec.valid};
            r_out_vld <= r_vld[NST-1];
        end
    end

    // Stage 0: absolute values and maximum.
    function automatic logic [AW-1:0] abs_of(input logic [DATA_WIDTH-1:0] v);
        logic [AW-1:0] e;
        e = {v[DATA_WIDTH-1], v};
        return v[DATA_WIDTH-1] ? AW'(-e) : e;
    endfunction

    logic [AW-1:0] ax, ay, az, mx;
    always_comb begin
        ax = abs_of(i_vec.data[DATA_WIDTH-1:0]);
        ay = abs_of(i_vec.data[DATA_WIDTH +: DATA_WIDTH]);
        az = abs_of(i_vec.data[2*DATA_WIDTH +: DATA_WIDTH]);
        mx = ax;
        if (ay > mx) mx = ay;
        if (az > mx) mx = az;
    end

    logic [AW-1:0]       d_w   [NDIV+1];
    logic [3*(AW+1)-1:0] d_rem [NDIV+1];
    logic [3*QW-1:0]     d_quo [NDIV+1];
    logic [3*AW-1:0]     d_num [NDIV+1];
    logic [AW-1:0]       d_aux [NDIV+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            d_w[0]   <= mx;
            d_rem[0] <= '0;
            d_quo[0] <= '0;
            d_num[0] <= {az, ay, ax};
            d_aux[0] <= mx;
        end
    end

    // Numerator is a << FRAC_BITS; the low zero bits are shifted in by the cells.
    for (genvar g = 0; g < NDIV; g++) begin : g_div
        svm_div_cell #(.AW(AW), .QW(QW)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_w(d_w[g]), .i_rem(d_rem[g]), .i_quo(d_quo[g]),
            .i_num(d_num[g]), .i_aux(d_aux[g]),
            .o_w(d_w[g+1]), .o_rem(d_rem[g+1]), .o_quo(d_quo[g+1]),
            .o_num(d_num[g+1]), .o_aux(d_aux[g+1])
        );
    end

    // Squares, then sum. A zero w gives all-ones quotients, cleared here.
    logic [2*QW-1:0] r_sq [3];
    logic [AW-1:0]   r_w1, r_w2;
    logic [SW-1:0]   r_sum;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= (d_aux[NDIV] == '0) ? '0
                         : d_quo[NDIV][k*QW +: QW] * d_quo[NDIV][k*QW +: QW];
            end
            r_w1  <= d_aux[NDIV];
            r_sum <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_w2  <= r_w1;
        end
    end

    logic [SW-1:0] s_num  [NSQ+1];
    logic [RW:0]   s_rem  [NSQ+1];
    logic [RW-1:0] s_root [NSQ+1];
    logic [AW-1:0] s_w    [NSQ+1];
    assign s_num[0]  = r_sum;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_w[0]    = r_w2;

    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        svm_sqrt_cell #(.NW(SW), .RW(RW), .AW(AW)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_num(s_num[g]), .i_rem(s_rem[g]), .i_root(s_root[g]), .i_w(s_w[g]),
            .o_num(s_num[g+1]), .o_rem(s_rem[g+1]), .o_root(s_root[g+1]),
            .o_w(s_w[g+1])
        );
    end

    // Scale back by w.
    logic [PW-1:0] r_prod;
    logic [PW-1:0] shifted;
    assign shifted = r_prod >> FRAC_BITS;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= PW'(s_w[NSQ]) * PW'(s_root[NSQ]);
            r_out  <= OUT_WIDTH'(shifted);
        end
    end

    `include "scaled_vector3_magnitude_core_assert.svh"
    `SVM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_mag.valid && !o_mag.ready, o_mag.valid && $stable(o_mag.data))
    `SVM_ASSERT_IMP(a_ready_free, i_clk, i_rst_n, !o_mag.valid, i_vec.ready)
    `SVM_ASSERT_NEXT(a_result_seq, i_clk, i_rst_n,
        en && r_vld[NST-1], o_mag.valid)
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for scaled_vector3_magnitude_core.
// Depends on svm_pkg, svm_if and the core. A local predictor computes the scaled
// vector length of every accepted vector, and the results are checked in order.
module tb_top import svm_pkg::*;;

    localparam int unsigned DW        = DEF_DATA_WIDTH;
    localparam int unsigned FB        = DEF_FRAC_BITS;
    localparam int unsigned LATENCY   = 2 * FB + DW + 8;
    localparam int unsigned N_RANDOM  = 1830;
    localparam int unsigned CYCLE_MAX = 500000;
    localparam int unsigned MAX_SHOWN = 10;

    localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINUS_1  = {DW{1'b1}};

    typedef struct packed {
        logic [DW-1:0] comp_z;
        logic [DW-1:0] comp_y;
        logic [DW-1:0] comp_x;
    } vector_t;

    // One directed row: the vector and, where it is obvious, its length.
    typedef struct {
        vector_t         vec;
        bit              known;
        logic [OUT_WIDTH-1:0] length;
    } directed_row_t;

    logic i_clk;
    logic i_rst_n;

    svm_if #(.W(3 * DW))    vec_if ();
    svm_if #(.W(OUT_WIDTH)) mag_if ();

    scaled_vector3_magnitude_core #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FB)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vec  (vec_if),
        .o_mag  (mag_if)
    );

    logic [OUT_WIDTH-1:0] pending_lengths[$];
    logic [OUT_WIDTH-1:0] typed_lengths[$];
    bit                   typed_valid[$];
    int unsigned          n_sent;
    int unsigned          n_checked = 0;
    int unsigned          n_mismatch = 0;
    int unsigned          n_cycles = 0;
    int unsigned          n_stalled_in = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Integer square root, one result bit per step.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned abs_component(logic [DW-1:0] c);
        longint unsigned full;
        full = 64'd1 << DW;
        return c[DW-1] ? full - longint'(c) : longint'(c);
    endfunction

    // Expected length: scale by the largest magnitude, root of the squared
    // fractions, then scale back.
    function automatic logic [OUT_WIDTH-1:0] vector_length(vector_t v);
        longint unsigned ax, ay, az, w, qx, qy, qz, s;
        ax = abs_component(v.comp_x);
        ay = abs_component(v.comp_y);
        az = abs_component(v.comp_z);
        w = ax;
        if (ay > w) w = ay;
        if (az > w) w = az;
        if (w == 0)
            return '0;
        qx = (ax << FB) / w;
        qy = (ay << FB) / w;
        qz = (az << FB) / w;
        s = int_sqrt(qx * qx + qy * qy + qz * qz);
        return OUT_WIDTH'((w * s) >> FB);
    endfunction

    // Component drawn from one of several shapes so that both tiny and
    // huge ratios between the components occur.
    function automatic logic [DW-1:0] random_component();
        logic [DW-1:0] c;
        case ($urandom_range(0, 5))
            0, 1: c = $urandom;
            2: c = DW'($urandom_range(0, 300));
            3: c = -DW'($urandom_range(0, 300));
            4: begin
                case ($urandom_range(0, 4))
                    0: c = '0;
                    1: c = MOST_NEG;
                    2: c = MOST_POS;
                    3: c = MINUS_1;
                    default: c = DW'(1);
                endcase
            end
            default: c = $urandom >> $urandom_range(0, DW - 1);
        endcase
        return c;
    endfunction

    // Acceptance monitor: records the expectation of every input transfer and counts stalled input cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && vec_if.valid && vec_if.ready) begin
            pending_lengths.push_back(vector_length(vec_if.data));
        end
        if (i_rst_n && vec_if.valid && !vec_if.ready)
            n_stalled_in++;
    end

    // Result checker: every output transfer against the oldest expectation.
    always @(posedge i_clk) begin
        logic [OUT_WIDTH-1:0] want;
        if (i_rst_n && mag_if.valid && mag_if.ready) begin
            if (pending_lengths.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_SHOWN)
                    $display("unexpected result %0d with nothing pending", mag_if.data);
            end else begin
                want = pending_lengths.pop_front();
                if (typed_valid.size() != 0) begin
                    if (typed_valid.pop_front())
                        want = typed_lengths[0];
                    void'(typed_lengths.pop_front());
                end
                n_checked++;
                if (mag_if.data !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_SHOWN)
                        $display("result %0d: magnitude expected %0d, got %0d",
                                 n_checked, want, mag_if.data);
                end
            end
        end
    end

    // Receiver: stall pattern that rotates through four modes, plus one long
    // hold-off that lets the pipeline fill and back-pressure the input.
    always @(posedge i_clk) begin
        int unsigned mode;
        mode = (n_cycles / 64) % 4;
        if (!i_rst_n) begin
            mag_if.ready <= 1'b0;
        end else if (n_cycles >= 1000 && n_cycles < 1400) begin
            mag_if.ready <= 1'b0;
        end else begin
            case (mode)
                0: mag_if.ready <= 1'b1;
                1: mag_if.ready <= ($urandom_range(0, 1) == 1);
                2: mag_if.ready <= ($urandom_range(0, 7) != 0);
                default: mag_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_MAX) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one vector and holds it until the core accepts it.
    task automatic offer_vector(vector_t v);
        vec_if.valid <= 1'b1;
        vec_if.data  <= v;
        do
            @(posedge i_clk);
        while (!vec_if.ready);
        n_sent++;
    endtask

    task automatic idle_cycles(int unsigned n);
        if (n == 0)
            return;
        vec_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Waits until every sent vector has had its result checked.
    task automatic wait_drained();
        vec_if.valid <= 1'b0;
        while (n_checked < n_sent)
            @(posedge i_clk);
    endtask

    directed_row_t directed[] = '{
        '{'{'0, '0, '0},                        1'b1, 32'd0},
        '{'{'0, '0, MOST_NEG},                  1'b1, 32'h8000_0000},
        '{'{'0, '0, MOST_POS},                  1'b1, 32'h7FFF_FFFF},
        '{'{'0, MINUS_1, '0},                   1'b1, 32'd1},
        '{'{'0, 32'd4, 32'd3},                  1'b1, 32'd5},
        '{'{32'd1, '0, '0},                     1'b1, 32'd1},
        '{'{MOST_NEG, MOST_NEG, MOST_NEG},      1'b0, '0},
        '{'{MOST_POS, MOST_POS, MOST_POS},      1'b0, '0},
        '{'{MOST_NEG, MOST_POS, MINUS_1},       1'b0, '0},
        '{'{32'd1, 32'd1, 32'd1},               1'b0, '0},
        '{'{MINUS_1, MINUS_1, MINUS_1},         1'b0, '0},
        '{'{32'd1, MOST_NEG, 32'd1},            1'b0, '0},
        '{'{-32'd12, 32'd4, 32'd3},             1'b0, '0},
        '{'{32'hAAAA_AAAA, 32'h5555_5555, '0},  1'b0, '0},
        '{'{32'h5555_5555, 32'hAAAA_AAAA, MOST_POS}, 1'b0, '0},
        '{'{32'd7, 32'd65535, 32'd65536},       1'b0, '0}
    };

    initial begin
        vector_t v;
        int unsigned burst;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        vec_if.valid = 1'b0;
        vec_if.data  = '0;
        n_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; obvious lengths are typed in, the rest predicted.
        foreach (directed[i]) begin
            typed_valid.push_back(directed[i].known);
            typed_lengths.push_back(directed[i].length);
            offer_vector(directed[i].vec);
        end
        wait_drained();

        // Random vectors in bursts of random length. One pause partway waits
        // until every result is back before the traffic resumes.
        for (int unsigned i = 0; i < N_RANDOM; ) begin
            burst = $urandom_range(1, 24);
            for (int unsigned k = 0; k < burst && i < N_RANDOM; k++, i++) begin
                v.comp_x = random_component();
                v.comp_y = random_component();
                v.comp_z = random_component();
                offer_vector(v);
                if (i == 1200)
                    wait_drained();
            end
            if ($urandom_range(0, 9) < 4)
                continue;
            idle_cycles($urandom_range(1, 8));
        end
        wait_drained();
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("Sent %0d vectors, checked %0d lengths, input stalled %0d cycles.",
                 n_sent, n_checked, n_stalled_in);
        $display("Covered zero, extreme and random components under random back-pressure.");
        if (n_mismatch == 0 && pending_lengths.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     n_mismatch, pending_lengths.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
